[hdl/srva_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Section RVA translator package
// Shared types, sizes and constants of the section table translator.
// ---------------------------------------------------------------------------
package srva_pkg;

  // Table depth and the widths that follow from it.
  localparam int MAX_SECTIONS = 16;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Datapath and interface widths.
  localparam int WORD_W = 32;
  localparam int DIV_CNT_W = $clog2(WORD_W);
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 4 * WORD_W;
  localparam int OUT_DATA_W = WORD_W;

  // Alignment constants.
  localparam logic [WORD_W-1:0] FILE_ROUND = 32'h0000_0200;
  localparam logic [WORD_W-1:0] SECT_THRESHOLD = 32'h0000_1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILE_ALIGN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECT_ALIGN = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [WORD_W-1:0] FILE_ALIGN_RST = 32'h0000_0200;
  localparam logic [WORD_W-1:0] SECT_ALIGN_RST = 32'h0000_1000;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_APPEND    = 2'd1,
    ACT_TRANSLATE = 2'd2
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV,
    ST_CALC,
    ST_FINISH
  } state_t;

  // One section table entry.
  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] raw;
  } sect_t;

  // Table write request.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    sect_t            entry;
  } tbl_wr_t;

endpackage : srva_pkg
`default_nettype wire

[hdl/srva_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Section table memory
// One write port and one registered read port over the loaded sections.
// ---------------------------------------------------------------------------
module srva_table (
  input  wire logic                       clk,
  input  wire srva_pkg::tbl_wr_t          wr,
  input  wire logic [srva_pkg::IDX_W-1:0] rd_addr,
  output srva_pkg::sect_t                 rd_entry
);

  srva_pkg::sect_t mem [srva_pkg::MAX_SECTIONS];

  // Write the appended section.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  // Registered read of the entry under scan.
  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

endmodule : srva_table
`default_nettype wire

[hdl/srva_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one quotient bit per cycle, giving the remainder.
// ---------------------------------------------------------------------------
module srva_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [srva_pkg::WORD_W-1:0] dividend,
  input  wire logic [srva_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic [srva_pkg::WORD_W-1:0]      remainder
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [srva_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [srva_pkg::WORD_W:0]       rem_r, rem_nxt;
  logic [srva_pkg::WORD_W-1:0]     dvd_r, dvd_nxt;
  logic [srva_pkg::WORD_W-1:0]     den_r, den_nxt;
  logic [srva_pkg::WORD_W:0]       shifted;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    shifted  = {rem_r[srva_pkg::WORD_W-1:0], dvd_r[srva_pkg::WORD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
      end else begin
        rem_nxt = shifted;
      end
      dvd_nxt = {dvd_r[srva_pkg::WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == srva_pkg::DIV_CNT_W'(srva_pkg::WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[srva_pkg::WORD_W-1:0];

endmodule : srva_divider
`default_nettype wire

[hdl/section_rva_to_file_offset_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Section RVA to file offset translator
// Keeps a table of image sections and translates relative virtual addresses.
// ---------------------------------------------------------------------------
// A clear or append request leaves the sequencer idle, so in_tready stays high.
// A translate request scans the table in load order, each section with a
// registered table read, then the range compare, and on a hit runs the
// restoring remainder unit to round the section start down to the effective
// alignment (skipped when that alignment is zero), followed by the calc state,
// which forms the offset, and the finish state, which registers it. The result
// sits in an output register, so the next request is taken while the previous
// result waits; the next translation holds in its last state until that
// register is free. There is no clearing pass after reset.
module section_rva_to_file_offset_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input request stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata, from bit 0: sect_virtual_start, sect_virtual_length,
  // sect_raw_pointer, query_rva.
  input  wire logic [srva_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser, from bit 0: action.
  input  wire logic [1:0]                      in_tuser,
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata, from bit 0: file_offset.
  output logic [srva_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser, from bit 0: found.
  output logic [0:0]                           out_tuser,
  // Configuration writes.
  input  wire logic                            cfg_we,
  input  wire logic [srva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srva_pkg::WORD_W-1:0]     cfg_wdata
);

  localparam int W = srva_pkg::WORD_W;

  srva_pkg::state_t              state_r, state_nxt;
  logic [W-1:0]                  file_align_r, section_align_r;
  logic [srva_pkg::CNT_W-1:0]    count_r, idx_r;
  logic [W-1:0]                  rva_r, base_r, sect_start_r, start_rnd_r;
  logic [W-1:0]                  res_off_r;
  logic                          res_found_r;
  logic                          out_valid_r;
  logic [W-1:0]                  out_off_r;
  logic                          out_found_r;

  srva_pkg::action_t             action;
  srva_pkg::tbl_wr_t             tbl_wr;
  srva_pkg::sect_t               rd_entry;
  logic [W-1:0]                  eff_align, raw_rnd, sect_end;
  logic                          accept, hit, last_idx, out_free;
  logic                          div_start, div_done;
  logic [W-1:0]                  div_rem;

  assign action   = srva_pkg::action_t'(in_tuser);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Effective alignment and raw pointer rounding.
  assign eff_align = (section_align_r < srva_pkg::SECT_THRESHOLD) ? file_align_r
                                                                   : section_align_r;
  assign raw_rnd = (file_align_r < srva_pkg::FILE_ROUND) ? rd_entry.raw
                   : (rd_entry.raw & ~(srva_pkg::FILE_ROUND - 1'b1));

  // Range compare of the entry under scan; the end wraps modulo 2^32.
  assign sect_end = rd_entry.start + rd_entry.length;
  assign hit      = (rva_r >= rd_entry.start) && (rva_r < sect_end);
  assign last_idx = ((idx_r + 1'b1) == count_r);

  // Table write request for an append that fits.
  always_comb begin
    tbl_wr.we = accept && (action == srva_pkg::ACT_APPEND) &&
                (count_r < srva_pkg::CNT_W'(srva_pkg::MAX_SECTIONS));
    tbl_wr.addr         = count_r[srva_pkg::IDX_W-1:0];
    tbl_wr.entry.start  = in_tdata[W-1:0];
    tbl_wr.entry.length = in_tdata[2*W-1:W];
    tbl_wr.entry.raw    = in_tdata[3*W-1:2*W];
  end

  srva_table u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd_addr  (idx_r[srva_pkg::IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  srva_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd_entry.start),
    .divisor   (eff_align),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srva_pkg::ST_IDLE: begin
        if (accept && (action == srva_pkg::ACT_TRANSLATE)) begin
          if (count_r == '0) begin
            state_nxt = srva_pkg::ST_FINISH;
          end else begin
            state_nxt = srva_pkg::ST_SCAN_RD;
          end
        end
      end
      srva_pkg::ST_SCAN_RD: begin
        state_nxt = srva_pkg::ST_SCAN_CMP;
      end
      srva_pkg::ST_SCAN_CMP: begin
        if (hit) begin
          if (eff_align == '0) begin
            state_nxt = srva_pkg::ST_CALC;
          end else begin
            state_nxt = srva_pkg::ST_DIV;
          end
        end else if (last_idx) begin
          state_nxt = srva_pkg::ST_FINISH;
        end else begin
          state_nxt = srva_pkg::ST_SCAN_RD;
        end
      end
      srva_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = srva_pkg::ST_CALC;
        end
      end
      srva_pkg::ST_CALC: begin
        state_nxt = srva_pkg::ST_FINISH;
      end
      srva_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = srva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srva_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = (state_r == srva_pkg::ST_IDLE);
    div_start = (state_r == srva_pkg::ST_SCAN_CMP) && hit && (eff_align != '0);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= srva_pkg::ST_IDLE;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
      file_align_r    <= srva_pkg::FILE_ALIGN_RST;
      section_align_r <= srva_pkg::SECT_ALIGN_RST;
    end else begin
      state_r <= state_nxt;
      // Configuration writes; other indexes are ignored.
      if (cfg_we) begin
        if (cfg_index == srva_pkg::REG_FILE_ALIGN) begin
          file_align_r <= cfg_wdata;
        end else if (cfg_index == srva_pkg::REG_SECT_ALIGN) begin
          section_align_r <= cfg_wdata;
        end
      end
      // Table fill count.
      if (accept && (action == srva_pkg::ACT_CLEAR)) begin
        count_r <= '0;
      end else if (tbl_wr.we) begin
        count_r <= count_r + 1'b1;
      end
      // Output register valid.
      if ((state_r == srva_pkg::ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Translation datapath.
  always_ff @(posedge clk) begin
    if (accept && (action == srva_pkg::ACT_TRANSLATE)) begin
      rva_r       <= in_tdata[4*W-1:3*W];
      idx_r       <= '0;
      res_off_r   <= '0;
      res_found_r <= 1'b0;
    end
    if ((state_r == srva_pkg::ST_SCAN_CMP) && !hit) begin
      idx_r <= idx_r + 1'b1;
    end
    // On a hit keep the start and the address plus rounded raw pointer.
    if ((state_r == srva_pkg::ST_SCAN_CMP) && hit) begin
      sect_start_r <= rd_entry.start;
      start_rnd_r  <= rd_entry.start;
      base_r       <= rva_r + raw_rnd;
    end
    if ((state_r == srva_pkg::ST_DIV) && div_done) begin
      start_rnd_r <= sect_start_r - div_rem;
    end
    if (state_r == srva_pkg::ST_CALC) begin
      res_off_r   <= base_r - start_rnd_r;
      res_found_r <= 1'b1;
    end
    if ((state_r == srva_pkg::ST_FINISH) && out_free) begin
      out_off_r   <= res_off_r;
      out_found_r <= res_found_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_off_r;
  assign out_tuser[0] = out_found_r;

endmodule : section_rva_to_file_offset_top
`default_nettype wire

[hdl/srva_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Section RVA translator checker
// Port-level properties of the translator, bound to the top level.
// ---------------------------------------------------------------------------
module srva_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [1:0]                      in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [srva_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]                      out_tuser
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A miss always reports a zero offset.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss with nonzero offset");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // Clear and append requests leave the block ready on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != srva_pkg::ACT_TRANSLATE) |=> in_tready)
    else $error("not ready after table update");

  // A translate request keeps the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == srva_pkg::ACT_TRANSLATE) |=> !in_tready)
    else $error("ready during translation");

endmodule : srva_checker

bind section_rva_to_file_offset_top srva_checker u_srva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
